### hdl/limit_order_book_matcher_top_assert.svh
// Assertion macros for the order book matcher
`ifndef LIMIT_ORDER_BOOK_MATCHER_TOP_ASSERT_SVH
`define LIMIT_ORDER_BOOK_MATCHER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define OBM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define OBM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define OBM_ASSERT_IMP(label, clk, rst, ante, cons)
`define OBM_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

### hdl/obm_pkg.sv
// Shared types, constants and codes of the order book matcher
package obm_pkg;
   localparam int MAX_ORDERS_DEF = 256;
   localparam int PRICE_BITS     = 16;

   localparam logic [1:0] MODE_PLACE  = 2'd0;
   localparam logic [1:0] MODE_CANCEL = 2'd1;
   localparam logic [1:0] MODE_QUERY  = 2'd2;
   localparam logic [1:0] TIF_REST    = 2'd0;
   localparam logic [1:0] TIF_IOC     = 2'd1;
   localparam logic [1:0] TIF_FOK     = 2'd2;

   localparam logic [2:0] ST_RESTED    = 3'd0;
   localparam logic [2:0] ST_DONE      = 3'd1;
   localparam logic [2:0] ST_KILLED    = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_CANCELLED = 3'd4;
   localparam logic [2:0] ST_NOT_FOUND = 3'd5;
   localparam logic [2:0] ST_PRESENT   = 3'd6;
   localparam logic [2:0] ST_ABSENT    = 3'd7;

   localparam logic [39:0] VOL40_MAX = 40'hFF_FFFF_FFFF;

   typedef struct packed {
      logic [1:0]            mode;
      logic                  side;
      logic [PRICE_BITS-1:0] price;
      logic [31:0]           volume;
      logic [1:0]            tif;
      logic [31:0]           ord_ref;
   } req_type;

   typedef struct packed {
      logic [2:0]            status;
      logic [31:0]           filled_volume;
      logic [31:0]           remaining_volume;
      logic                  bid_valid;
      logic [PRICE_BITS-1:0] best_bid_price;
      logic [39:0]           best_bid_volume;
      logic                  ask_valid;
      logic [PRICE_BITS-1:0] best_ask_price;
      logic [39:0]           best_ask_volume;
      logic [16:0]           spread;
      logic [16:0]           mid_half_ticks;
   } rsp_type;

   // scan kinds run by the datapath
   typedef enum logic [2:0] {
      SCAN_FOK   = 3'd0,
      SCAN_BEST  = 3'd1,
      SCAN_ID    = 3'd2,
      SCAN_FREE  = 3'd3,
      SCAN_BOOK  = 3'd4,
      SCAN_LEVEL = 3'd5
   } scan_kind_type;

   typedef struct packed {
      logic          start;
      scan_kind_type kind;
      logic          side_sel;
      logic          fill;
      logic          remove;
      logic          rest;
      logic          take_req;
      logic          finish;
   } cmd_type;

   typedef struct packed {
      logic done;
      logic found;
      logic crosses;
      logic fok_short;
      logic remain_zero;
      logic req_is_place;
      logic req_is_cancel;
      logic req_tif_ioc;
      logic req_tif_fok;
      logic req_vol_zero;
      logic req_side;
   } sts_type;
endpackage

### hdl/obm_datapath.sv
// Order pool, slot scanner and matching arithmetic
module obm_datapath #(
   parameter int MAX_ORDERS = obm_pkg::MAX_ORDERS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  obm_pkg::req_type req_in,
   input  obm_pkg::cmd_type cmd,
   output obm_pkg::sts_type sts,
   output obm_pkg::rsp_type rsp_out
);
   localparam int PRICE_BITS = obm_pkg::PRICE_BITS;
   localparam int IW = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
   localparam int CW = IW + 1;

   logic [31:0]         mem_id    [MAX_ORDERS];
   logic                mem_side  [MAX_ORDERS];
   logic [PRICE_BITS-1:0] mem_price [MAX_ORDERS];
   logic [31:0]         mem_vol   [MAX_ORDERS];
   logic [31:0]         mem_arr   [MAX_ORDERS];
   logic [MAX_ORDERS-1:0] valid_ff;

   obm_pkg::req_type req_ff;
   logic [31:0] remain_ff, filled_ff, arrival_ff;
   logic [2:0]  status_ff;
   logic [32:0] avail_ff;
   logic        scan_ff;
   logic [CW-1:0] idx_ff;
   obm_pkg::scan_kind_type kind_ff;
   logic        sside_ff;
   logic        found_ff;
   logic [IW-1:0] hit_ff;
   logic [PRICE_BITS-1:0] hprice_ff;
   logic [31:0] hage_ff;
   logic [31:0] hvol_ff;
   logic [39:0] lvl_ff;
   logic        done_ff;
   logic        bid_v_ff, ask_v_ff;
   logic [PRICE_BITS-1:0] bid_p_ff, ask_p_ff;
   logic [39:0] bid_l_ff;
   obm_pkg::rsp_type rsp_ff;

   logic [31:0] rd_id, rd_vol, rd_arr;
   logic        rd_side, rd_valid;
   logic [PRICE_BITS-1:0] rd_price;
   logic        rd_pend;
   logic [IW-1:0] rd_idx;
   logic [PRICE_BITS-1:0] lim;
   logic        match_side;
   logic        better;
   logic [31:0] age;
   logic [40:0] lvl_sum;
   logic [33:0] av_sum;
   logic [31:0] trade;
   logic        res_cross;

   assign lim = req_ff.price;

   // read port: address idx, data registered and out in the next cycle
   always_ff @(posedge clock) begin
      rd_id    <= mem_id[idx_ff[IW-1:0]];
      rd_side  <= mem_side[idx_ff[IW-1:0]];
      rd_price <= mem_price[idx_ff[IW-1:0]];
      rd_vol   <= mem_vol[idx_ff[IW-1:0]];
      rd_arr   <= mem_arr[idx_ff[IW-1:0]];
      rd_valid <= valid_ff[idx_ff[IW-1:0]];
      rd_idx   <= idx_ff[IW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend <= 1'b0;
      end else begin
         rd_pend <= scan_ff && (idx_ff < CW'(MAX_ORDERS));
      end
   end

   assign age = arrival_ff - rd_arr;
   always_comb begin
      if (rd_price != hprice_ff) begin
         better = sside_ff ? (rd_price < hprice_ff) : (rd_price > hprice_ff);
      end else begin
         better = age > hage_ff;
      end
   end
   assign match_side = rd_valid && (rd_side == sside_ff);
   assign lvl_sum = {1'b0, lvl_ff} + {9'd0, rd_vol};
   assign av_sum = {1'b0, avail_ff} + {2'd0, rd_vol};
   assign res_cross = req_ff.side ? (hprice_ff >= lim) : (hprice_ff <= lim);
   assign trade = (remain_ff < hvol_ff) ? remain_ff : hvol_ff;

   always_ff @(posedge clock) begin
      if (cmd.rest) begin
         mem_id[hit_ff]    <= req_ff.ord_ref;
         mem_side[hit_ff]  <= req_ff.side;
         mem_price[hit_ff] <= lim;
         mem_vol[hit_ff]   <= remain_ff;
         mem_arr[hit_ff]   <= arrival_ff;
      end else if (cmd.fill) begin
         mem_vol[hit_ff]   <= hvol_ff - trade;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         arrival_ff <= '0;
         scan_ff    <= 1'b0;
         done_ff    <= 1'b0;
         idx_ff     <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.rest) begin
            valid_ff[hit_ff] <= 1'b1;
            arrival_ff       <= arrival_ff + 32'd1;
         end else if (cmd.remove) begin
            valid_ff[hit_ff] <= 1'b0;
         end else if (cmd.fill && (hvol_ff == trade)) begin
            valid_ff[hit_ff] <= 1'b0;
         end
         if (cmd.start) begin
            scan_ff <= 1'b1;
            idx_ff  <= '0;
         end else if (scan_ff) begin
            if (idx_ff < CW'(MAX_ORDERS)) begin
               idx_ff <= idx_ff + CW'(1);
            end
            if (!rd_pend && idx_ff == CW'(MAX_ORDERS)) begin
               scan_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
         if (scan_ff && rd_pend && (kind_ff == obm_pkg::SCAN_FREE) && !rd_valid
             && !found_ff) begin
            idx_ff <= CW'(MAX_ORDERS);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_req) begin
         req_ff    <= req_in;
         remain_ff <= (req_in.mode == obm_pkg::MODE_PLACE) ? req_in.volume : '0;
         filled_ff <= '0;
      end
      if (cmd.fill) begin
         remain_ff <= remain_ff - trade;
         filled_ff <= filled_ff + trade;
      end
      if (cmd.start) begin
         kind_ff  <= cmd.kind;
         sside_ff <= cmd.side_sel;
         found_ff <= 1'b0;
         avail_ff <= '0;
         lvl_ff   <= '0;
      end else if (rd_pend) begin
         unique case (kind_ff)
            obm_pkg::SCAN_FOK: begin
               if (match_side && (req_ff.side ? (rd_price >= lim) : (rd_price <= lim))
                   && !avail_ff[32]) begin
                  avail_ff <= av_sum[33] ? 33'h1_0000_0000 : av_sum[32:0];
               end
            end
            obm_pkg::SCAN_BEST, obm_pkg::SCAN_BOOK: begin
               if (match_side && (!found_ff || better)) begin
                  found_ff  <= 1'b1;
                  hit_ff    <= rd_idx;
                  hprice_ff <= rd_price;
                  hage_ff   <= age;
               end
            end
            obm_pkg::SCAN_ID: begin
               if (rd_valid && rd_id == req_ff.ord_ref && !found_ff) begin
                  found_ff <= 1'b1;
                  hit_ff   <= rd_idx;
                  remain_ff <= rd_vol;
               end
            end
            obm_pkg::SCAN_FREE: begin
               if (!rd_valid && !found_ff) begin
                  found_ff <= 1'b1;
                  hit_ff   <= rd_idx;
               end
            end
            obm_pkg::SCAN_LEVEL: begin
               if (match_side && rd_price == (sside_ff ? ask_p_ff : bid_p_ff)) begin
                  lvl_ff <= lvl_sum[40] ? obm_pkg::VOL40_MAX : lvl_sum[39:0];
               end
            end
            default: begin
            end
         endcase
      end
      if (done_ff && kind_ff == obm_pkg::SCAN_BOOK) begin
         if (sside_ff) begin
            ask_v_ff <= found_ff;
            ask_p_ff <= found_ff ? hprice_ff : '0;
         end else begin
            bid_v_ff <= found_ff;
            bid_p_ff <= found_ff ? hprice_ff : '0;
         end
      end
      if (done_ff && kind_ff == obm_pkg::SCAN_LEVEL && !sside_ff) begin
         bid_l_ff <= bid_v_ff ? lvl_ff : '0;
      end
   end

   // hold the volume of the best slot for the fill
   always_ff @(posedge clock) begin
      if (rd_pend && (kind_ff == obm_pkg::SCAN_BEST) && match_side && (!found_ff || better)) begin
         hvol_ff <= rd_vol;
      end
   end

   always_comb begin
      sts.done          = done_ff;
      sts.found         = found_ff;
      sts.crosses       = found_ff && res_cross;
      sts.fok_short     = avail_ff < {1'b0, req_ff.volume};
      sts.remain_zero   = remain_ff == '0;
      sts.req_is_place  = req_ff.mode == obm_pkg::MODE_PLACE;
      sts.req_is_cancel = req_ff.mode == obm_pkg::MODE_CANCEL;
      sts.req_tif_ioc   = req_ff.tif == obm_pkg::TIF_IOC;
      sts.req_tif_fok   = req_ff.tif == obm_pkg::TIF_FOK;
      sts.req_vol_zero  = req_ff.volume == '0;
      sts.req_side      = req_ff.side;
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_ff.status           <= status_ff;
         rsp_ff.filled_volume    <= filled_ff;
         rsp_ff.remaining_volume <= remain_ff;
         rsp_ff.bid_valid        <= bid_v_ff;
         rsp_ff.best_bid_price   <= bid_p_ff;
         rsp_ff.best_bid_volume  <= bid_l_ff;
         rsp_ff.ask_valid        <= ask_v_ff;
         rsp_ff.best_ask_price   <= ask_p_ff;
         rsp_ff.best_ask_volume  <= ask_v_ff ? lvl_ff : '0;
         rsp_ff.spread <= (bid_v_ff && ask_v_ff) ?
            17'({1'b0, ask_p_ff} - {1'b0, bid_p_ff}) : '0;
         rsp_ff.mid_half_ticks <= (bid_v_ff && ask_v_ff) ?
            17'({1'b0, ask_p_ff} + {1'b0, bid_p_ff}) : '0;
      end
   end

   // status code set from the results of the scans as each one ends
   always_ff @(posedge clock) begin
      if (cmd.take_req) begin
         status_ff <= obm_pkg::ST_DONE;
      end else if (done_ff) begin
         unique case (kind_ff)
            obm_pkg::SCAN_FOK: begin
               if (avail_ff < {1'b0, req_ff.volume}) status_ff <= obm_pkg::ST_KILLED;
            end
            obm_pkg::SCAN_ID: begin
               if (req_ff.mode == obm_pkg::MODE_CANCEL) begin
                  status_ff <= found_ff ? obm_pkg::ST_CANCELLED : obm_pkg::ST_NOT_FOUND;
               end else begin
                  status_ff <= found_ff ? obm_pkg::ST_PRESENT : obm_pkg::ST_ABSENT;
               end
            end
            obm_pkg::SCAN_FREE: begin
               status_ff <= found_ff ? obm_pkg::ST_RESTED : obm_pkg::ST_FULL;
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_out = rsp_ff;
endmodule

### hdl/obm_ctrl.sv
// Sequencer for scans, fills and result hand-off
module obm_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  obm_pkg::sts_type sts,
   output obm_pkg::cmd_type cmd
);
   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_FOK    = 10'b0000000010,
      S_BEST   = 10'b0000000100,
      S_FILL   = 10'b0000001000,
      S_ID     = 10'b0000010000,
      S_FREE   = 10'b0000100000,
      S_BOOKB  = 10'b0001000000,
      S_BOOKA  = 10'b0010000000,
      S_LVLB   = 10'b0100000000,
      S_LVLA   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic started_ff, started_in;
   logic rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      started_in   = started_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.kind     = obm_pkg::SCAN_BEST;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.take_req = 1'b1;
               started_in   = 1'b0;
               state_in     = S_FOK;
            end
         end
         S_FOK: begin
            cmd.kind = obm_pkg::SCAN_FOK;
            cmd.side_sel = !sts.req_side;
            if (!sts.req_is_place) begin
               state_in = S_ID;
            end else if (sts.req_vol_zero) begin
               state_in = S_BOOKB;
            end else if (!sts.req_tif_fok) begin
               state_in = S_BEST;
            end else if (!started_ff) begin
               cmd.start = 1'b1;
               started_in = 1'b1;
            end else if (sts.done) begin
               started_in = 1'b0;
               state_in = sts.fok_short ? S_BOOKB : S_BEST;
            end
         end
         default: begin
         end
      endcase
      if (state_ff != S_IDLE && state_ff != S_FOK) begin
         unique case (state_ff)
            S_BEST: cmd.kind = obm_pkg::SCAN_BEST;
            S_ID: cmd.kind = obm_pkg::SCAN_ID;
            S_FREE: cmd.kind = obm_pkg::SCAN_FREE;
            S_BOOKB, S_BOOKA: cmd.kind = obm_pkg::SCAN_BOOK;
            default: cmd.kind = obm_pkg::SCAN_LEVEL;
         endcase
         cmd.side_sel = (state_ff == S_BOOKA) || (state_ff == S_LVLA) ||
                        ((state_ff == S_BEST) && !sts.req_side) ? 1'b1 : 1'b0;
      end
      state_in = state_in;
      unique case (state_ff)
         S_IDLE, S_FOK: begin
         end
         S_FILL: begin
            cmd.fill = 1'b1;
            state_in = S_BEST;
         end
         default: begin
            if (!started_ff) begin
               cmd.start = 1'b1;
               started_in = 1'b1;
            end else if (sts.done) begin
               started_in = 1'b0;
               unique case (state_ff)
                  S_BEST: begin
                     if (sts.crosses && !sts.remain_zero) begin
                        state_in = S_FILL;
                     end else if (sts.remain_zero || sts.req_tif_ioc) begin
                        state_in = S_BOOKB;
                     end else begin
                        state_in = S_FREE;
                     end
                  end
                  S_ID: begin
                     cmd.remove = sts.found && sts.req_is_cancel;
                     state_in = S_BOOKB;
                  end
                  S_FREE: begin
                     cmd.rest = sts.found;
                     state_in = S_BOOKB;
                  end
                  S_BOOKB: state_in = S_BOOKA;
                  S_BOOKA: state_in = S_LVLB;
                  S_LVLB: state_in = S_LVLA;
                  default: begin
                     cmd.finish = 1'b1;
                     rsp_valid_in = 1'b1;
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         started_ff   <= started_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

### hdl/limit_order_book_matcher_top.sv
// Top level of the price-time order book matcher
//  channel | direction | beat
//  req     | in        | one command (place, cancel, query)
//  rsp     | out       | status, fills and top of book
// A pool scan walks the slots in turn; the free-slot scan stops at a free slot.
// Cancel and query: one id scan plus four top-of-book scans (bid, ask, both levels).
// Place: one best-price scan per fill plus one, a fill step for each fill, a free-slot scan when
// the remainder rests, then the four top-of-book scans; fill-or-kill adds one scan.
// Reset clears the valid bits and the arrival counter at once; no clearing pass.
// A new beat is taken only after the previous response has been taken.
`include "limit_order_book_matcher_top_assert.svh"
module limit_order_book_matcher_top #(
   parameter int MAX_ORDERS = obm_pkg::MAX_ORDERS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  obm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output obm_pkg::rsp_type rsp_data
);
   obm_pkg::cmd_type cmd;
   obm_pkg::sts_type sts;

   obm_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .sts, .cmd
   );

   obm_datapath #(.MAX_ORDERS(MAX_ORDERS)) u_dp (
      .clock, .reset, .req_in(req_data), .cmd, .sts, .rsp_out(rsp_data)
   );

   `OBM_ASSERT_IMP(a_no_take_while_rsp, clock, reset, rsp_valid, !req_ready)
   `OBM_ASSERT_NXT(a_rsp_after_finish, clock, reset, cmd.finish, rsp_valid)
   `OBM_ASSERT_IMP(a_one_write, clock, reset, cmd.rest, !cmd.remove && !cmd.fill)
endmodule

### tb/sv/tb.sv
// Self-checking testbench for the price-time order book matcher
module tb;
   localparam int POOL = 256;
   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam logic [1:0] TIF_SPARE  = 2'd3;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   obm_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   obm_pkg::rsp_type rsp_data;

   limit_order_book_matcher_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // book model state
   logic        bk_valid [POOL];
   logic [31:0] bk_id [POOL];
   logic        bk_side [POOL];
   logic [15:0] bk_price [POOL];
   logic [31:0] bk_vol [POOL];
   logic [31:0] bk_stamp [POOL];
   logic [31:0] stamp_ctr;

   obm_pkg::req_type pending_reqs[$];
   bit               drain_first[$];
   obm_pkg::rsp_type book_expect[$];
   logic [31:0]      known_ids[$];
   int          mismatches = 0;
   int          beats_in = 0;
   int          beats_out = 0;
   int          status_seen [8];
   bit          calm = 1'b0;
   int          send_gap = 0;
   int          take_gap = 0;

   function automatic int top_slot(logic s);
      int best;
      best = -1;
      for (int i = 0; i < POOL; i++) begin
         if (!bk_valid[i] || bk_side[i] != s) continue;
         if (best < 0) begin
            best = i;
         end else if (bk_price[i] != bk_price[best]) begin
            if (s == 1'b0 ? bk_price[i] > bk_price[best] : bk_price[i] < bk_price[best])
               best = i;
         end else if (32'(stamp_ctr - bk_stamp[i]) > 32'(stamp_ctr - bk_stamp[best])) begin
            best = i;
         end
      end
      return best;
   endfunction

   function automatic bit crossing(logic s, logic [15:0] lim, logic [15:0] rp);
      return s == 1'b0 ? rp <= lim : rp >= lim;
   endfunction

   function automatic logic [39:0] level_sum(logic s, logic [15:0] p);
      logic [63:0] sum;
      sum = 0;
      for (int i = 0; i < POOL; i++)
         if (bk_valid[i] && bk_side[i] == s && bk_price[i] == p) sum += bk_vol[i];
      return sum > 64'(obm_pkg::VOL40_MAX) ? obm_pkg::VOL40_MAX : sum[39:0];
   endfunction

   function automatic obm_pkg::rsp_type book_step(obm_pkg::req_type r);
      obm_pkg::rsp_type o;
      logic        opp;
      logic [63:0] avail;
      logic [31:0] remain, fill, tr;
      int          b, f, bb, ba;
      o = '0;
      opp = ~r.side;
      if (r.mode == obm_pkg::MODE_PLACE) begin
         avail = 0;
         if (r.tif == obm_pkg::TIF_FOK)
            for (int i = 0; i < POOL; i++)
               if (bk_valid[i] && bk_side[i] == opp && crossing(r.side, r.price, bk_price[i]))
                  avail += bk_vol[i];
         remain = r.volume;
         fill = 0;
         if (r.tif == obm_pkg::TIF_FOK && avail < 64'(r.volume)) begin
            o.status = obm_pkg::ST_KILLED;
         end else begin
            for (int n = 0; n <= POOL && remain != 0; n++) begin
               b = top_slot(opp);
               if (b < 0 || !crossing(r.side, r.price, bk_price[b])) break;
               tr = remain < bk_vol[b] ? remain : bk_vol[b];
               remain -= tr;
               fill += tr;
               bk_vol[b] -= tr;
               if (bk_vol[b] == 0) bk_valid[b] = 1'b0;
            end
            if (remain == 0 || r.tif == obm_pkg::TIF_IOC) begin
               o.status = obm_pkg::ST_DONE;
            end else begin
               f = -1;
               for (int i = 0; i < POOL; i++)
                  if (!bk_valid[i]) begin
                     f = i;
                     break;
                  end
               if (f < 0) begin
                  o.status = obm_pkg::ST_FULL;
               end else begin
                  bk_valid[f] = 1'b1;
                  bk_id[f] = r.ord_ref;
                  bk_side[f] = r.side;
                  bk_price[f] = r.price;
                  bk_vol[f] = remain;
                  bk_stamp[f] = stamp_ctr;
                  stamp_ctr++;
                  o.status = obm_pkg::ST_RESTED;
               end
            end
         end
         o.filled_volume = fill;
         o.remaining_volume = remain;
      end else begin
         o.status = r.mode == obm_pkg::MODE_CANCEL ? obm_pkg::ST_NOT_FOUND : obm_pkg::ST_ABSENT;
         for (int i = 0; i < POOL; i++)
            if (bk_valid[i] && bk_id[i] == r.ord_ref) begin
               o.remaining_volume = bk_vol[i];
               if (r.mode == obm_pkg::MODE_CANCEL) begin
                  bk_valid[i] = 1'b0;
                  o.status = obm_pkg::ST_CANCELLED;
               end else begin
                  o.status = obm_pkg::ST_PRESENT;
               end
               break;
            end
      end
      bb = top_slot(1'b0);
      ba = top_slot(1'b1);
      if (bb >= 0) begin
         o.bid_valid = 1'b1;
         o.best_bid_price = bk_price[bb];
         o.best_bid_volume = level_sum(1'b0, bk_price[bb]);
      end
      if (ba >= 0) begin
         o.ask_valid = 1'b1;
         o.best_ask_price = bk_price[ba];
         o.best_ask_volume = level_sum(1'b1, bk_price[ba]);
      end
      if (bb >= 0 && ba >= 0) begin
         o.spread = 17'({1'b0, o.best_ask_price}) - 17'({1'b0, o.best_bid_price});
         o.mid_half_ticks = 17'(o.best_ask_price) + 17'(o.best_bid_price);
      end
      return o;
   endfunction

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // drive the request channel
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            book_expect.insert(book_expect.size(), book_step(req_data));
            beats_in++;
            send_gap = idle_len();
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0 &&
                         !(drain_first[0] && book_expect.size() > 0) &&
                         !(drain_first[0] && req_valid)) begin
               req_data <= pending_reqs[0];
               pending_reqs.delete(0);
               drain_first.delete(0);
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch on response %0d, %s: expected %0h, got %0h",
                     beats_out, name, want, got);
      end
   endtask

   // check the response channel
   always @(posedge clock) begin
      obm_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (book_expect.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response beat %0h", rsp_data);
            end else begin
               want = book_expect[0];
               book_expect.delete(0);
               check_field("status", want.status, rsp_data.status);
               check_field("filled_volume", want.filled_volume, rsp_data.filled_volume);
               check_field("remaining_volume", want.remaining_volume,
                           rsp_data.remaining_volume);
               check_field("bid_valid", want.bid_valid, rsp_data.bid_valid);
               check_field("best_bid_price", want.best_bid_price, rsp_data.best_bid_price);
               check_field("best_bid_volume", want.best_bid_volume, rsp_data.best_bid_volume);
               check_field("ask_valid", want.ask_valid, rsp_data.ask_valid);
               check_field("best_ask_price", want.best_ask_price, rsp_data.best_ask_price);
               check_field("best_ask_volume", want.best_ask_volume, rsp_data.best_ask_volume);
               check_field("spread", want.spread, rsp_data.spread);
               check_field("mid_half_ticks", want.mid_half_ticks, rsp_data.mid_half_ticks);
               status_seen[want.status]++;
            end
            beats_out++;
         end
         if (take_gap > 0) begin
            take_gap--;
            rsp_ready <= 1'b0;
         end else begin
            take_gap = idle_len();
            rsp_ready <= take_gap == 0;
         end
      end
   end

   task automatic add_order(logic [1:0] mode, logic side, logic [15:0] price,
                            logic [31:0] vol, logic [1:0] tif, logic [31:0] id,
                            bit drain = 1'b0);
      obm_pkg::req_type r;
      r.mode = mode;
      r.side = side;
      r.price = price;
      r.volume = vol;
      r.tif = tif;
      r.ord_ref = id;
      pending_reqs.insert(pending_reqs.size(), r);
      drain_first.insert(drain_first.size(), drain);
      if (mode == obm_pkg::MODE_PLACE) known_ids.insert(known_ids.size(), id);
   endtask

   function automatic logic [31:0] pick_id();
      if (known_ids.size() > 0 && $urandom_range(0, 9) < 8)
         return known_ids[$urandom_range(0, known_ids.size() - 1)];
      return $urandom;
   endfunction

   task automatic add_random();
      int          m, t;
      logic [1:0]  mode, tif;
      logic [15:0] price;
      logic [31:0] vol;
      m = $urandom_range(0, 99);
      mode = m < 60 ? obm_pkg::MODE_PLACE : m < 80 ? obm_pkg::MODE_CANCEL :
             m < 95 ? obm_pkg::MODE_QUERY : MODE_SPARE;
      price = $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(32740, 32796));
      t = $urandom_range(0, 19);
      vol = t == 0 ? 32'd0 : t < 3 ? 32'($urandom) : 32'($urandom_range(1, 1000));
      t = $urandom_range(0, 9);
      tif = t < 5 ? obm_pkg::TIF_REST : t < 7 ? obm_pkg::TIF_IOC :
            t < 9 ? obm_pkg::TIF_FOK : TIF_SPARE;
      if (mode == obm_pkg::MODE_PLACE)
         add_order(mode, 1'($urandom), price, vol, tif, $urandom);
      else
         add_order(mode, 1'($urandom), price, vol, tif, pick_id());
   endtask

   initial begin
      foreach (bk_valid[i]) begin
         bk_valid[i] = 1'b0;
         bk_id[i] = '0;
         bk_side[i] = 1'b0;
         bk_price[i] = '0;
         bk_vol[i] = '0;
         bk_stamp[i] = '0;
      end
      stamp_ctr = '0;
      foreach (status_seen[i]) status_seen[i] = 0;

      add_order(obm_pkg::MODE_QUERY, 1'b0, 16'd0, 32'd0, obm_pkg::TIF_REST, 32'd0);
      add_order(obm_pkg::MODE_CANCEL, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, TIF_SPARE, 32'hFFFF_FFFF);
      add_order(obm_pkg::MODE_PLACE, 1'b0, 16'd0, 32'd1, obm_pkg::TIF_REST, 32'd1);
      add_order(obm_pkg::MODE_PLACE, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, obm_pkg::TIF_REST,
                32'hFFFF_FFFF);
      add_order(obm_pkg::MODE_PLACE, 1'b1, 16'd100, 32'd0, obm_pkg::TIF_FOK, 32'd2);
      add_order(obm_pkg::MODE_PLACE, 1'b0, 16'd50, 32'd40, obm_pkg::TIF_REST, 32'd3);
      add_order(obm_pkg::MODE_PLACE, 1'b0, 16'd50, 32'd60, obm_pkg::TIF_REST, 32'd3);
      add_order(obm_pkg::MODE_PLACE, 1'b1, 16'd40, 32'd500, obm_pkg::TIF_FOK, 32'd4);
      add_order(obm_pkg::MODE_PLACE, 1'b1, 16'd40, 32'd70, obm_pkg::TIF_FOK, 32'd5);
      add_order(obm_pkg::MODE_PLACE, 1'b1, 16'd0, 32'd80, obm_pkg::TIF_IOC, 32'd6);
      add_order(obm_pkg::MODE_PLACE, 1'b0, 16'd7, 32'd10, obm_pkg::TIF_REST, 32'd7);
      add_order(obm_pkg::MODE_PLACE, 1'b1, 16'd5, 32'd25, TIF_SPARE, 32'd8);
      add_order(obm_pkg::MODE_QUERY, 1'b0, 16'd0, 32'd0, obm_pkg::TIF_REST, 32'd8);
      add_order(MODE_SPARE, 1'b1, 16'd0, 32'd0, obm_pkg::TIF_REST, 32'd1);
      add_order(obm_pkg::MODE_PLACE, 1'b1, 16'd9, 32'd5, obm_pkg::TIF_REST, 32'd9);
      add_order(obm_pkg::MODE_PLACE, 1'b1, 16'd9, 32'd6, obm_pkg::TIF_REST, 32'd9);
      add_order(obm_pkg::MODE_CANCEL, 1'b0, 16'd0, 32'd0, obm_pkg::TIF_REST, 32'd9);
      add_order(obm_pkg::MODE_QUERY, 1'b0, 16'd0, 32'd0, obm_pkg::TIF_REST, 32'd9);
      add_order(obm_pkg::MODE_PLACE, 1'b0, 16'hFFFF, 32'hFFFF_FFFF, obm_pkg::TIF_FOK,
                32'h8000_0000);
      add_order(obm_pkg::MODE_PLACE, 1'b0, 16'hFFFF, 32'hFFFF_FFFF, obm_pkg::TIF_IOC,
                32'h5555_AAAA);

      for (int i = 0; i < 700; i++) add_random();
      // fill the pool past its size, then drain it
      for (int i = 0; i < 270; i++)
         add_order(obm_pkg::MODE_PLACE, 1'b0, 16'($urandom_range(1000, 1100)),
                   32'($urandom_range(1, 50)), obm_pkg::TIF_REST, 32'h4000_0000 + i, i == 0);
      add_order(obm_pkg::MODE_PLACE, 1'b1, 16'd1050, 32'd3000, obm_pkg::TIF_REST,
                32'h4100_0000);
      for (int i = 0; i < 150; i++)
         add_order(i % 5 == 4 ? obm_pkg::MODE_QUERY : obm_pkg::MODE_CANCEL, 1'b0, 16'd0,
                   32'd0, obm_pkg::TIF_REST, 32'h4000_0000 + $urandom_range(0, 269));
      for (int i = 0; i < 560; i++) add_random();

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      while (pending_reqs.size() > 0 || req_valid || book_expect.size() > 0) begin
         @(posedge clock);
         if ($urandom_range(0, 499) == 0) calm = ~calm;
      end
      repeat (3000) @(posedge clock);
      $display("%0d requests sent, %0d responses checked; rested %0d, done %0d, killed %0d,",
               beats_in, beats_out, status_seen[obm_pkg::ST_RESTED],
               status_seen[obm_pkg::ST_DONE], status_seen[obm_pkg::ST_KILLED]);
      $display("pool full %0d, cancelled %0d, not found %0d, present %0d, absent %0d",
               status_seen[obm_pkg::ST_FULL], status_seen[obm_pkg::ST_CANCELLED],
               status_seen[obm_pkg::ST_NOT_FOUND], status_seen[obm_pkg::ST_PRESENT],
               status_seen[obm_pkg::ST_ABSENT]);
      if (mismatches == 0 && book_expect.size() == 0)
         $display("limit_order_book_matcher_top regression: pass");
      else
         $display("limit_order_book_matcher_top regression: fail");
      $finish;
   end

   initial begin
      #1_000_000_000;
      $display("limit_order_book_matcher_top regression: fail");
      $finish;
   end
endmodule
